>>> rtl/ds_twr_range_calculator_top_assert.svh
// Assertion macros for the ranging pipeline
`ifndef DS_TWR_RANGE_CALCULATOR_TOP_ASSERT_SVH
`define DS_TWR_RANGE_CALCULATOR_TOP_ASSERT_SVH

// checked only out of reset
`define DTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DTR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dtr_pkg.sv
// Shared widths, constants and types of the ranging pipeline
`default_nettype none
package dtr_pkg;

  localparam int TS_BITS       = 40;
  localparam int TOF_FRAC_BITS = 4;
  localparam int DEN_W         = TS_BITS + 2;
  localparam int PROD_W        = 2 * TS_BITS;
  localparam int DVD_W         = PROD_W + TOF_FRAC_BITS;
  localparam int QUO_W         = TS_BITS + TOF_FRAC_BITS;
  localparam int REM_W         = DEN_W;
  localparam int HALF_W        = TS_BITS / 2;
  localparam int PP_W          = 2 * HALF_W;
  localparam int DLY_W         = 20;
  localparam int DIST_W        = 40;
  localparam int SCALE_W       = 23;
  localparam int MLO_W         = QUO_W / 2;
  localparam int MP_W          = MLO_W + SCALE_W;
  localparam int MSUM_W        = QUO_W + SCALE_W;
  localparam int RANGE_SHIFT   = 28;

  localparam logic [SCALE_W-1:0] RANGE_SCALE = 23'd7871474;
  localparam logic [DLY_W-1:0]   DLY_RESET   = 20'd528138;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_ZDEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [TS_BITS-1:0] poll_send_time;
    logic [TS_BITS-1:0] resp_recv_time;
    logic [TS_BITS-1:0] reply_delay_one;
    logic [TS_BITS-1:0] poll2_send_time;
    logic [TS_BITS-1:0] resp2_recv_time;
    logic [TS_BITS-1:0] reply_delay_two;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    status_t           status;
  } rsp_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DEN_W-1:0] den;
    status_t          st;
  } div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    status_t          st;
  } div_out_t;

endpackage
`default_nettype wire

>>> rtl/dtr_ifs.sv
// Request and response channel interfaces
`default_nettype none
interface dtr_req_if import dtr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtr_rsp_if import dtr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ds_twr_range_calculator_top.sv
// Pipeline: 7 stages plus 44 divider stages from request acceptance to result valid.
// Throughput: one request per cycle unless rsp stalls; the 44-stage divider sets the depth.
// Each stage holds its item on a stall and takes a new one once its slot frees.
// Reset (rst, synchronous) empties the pipeline and sets the antenna delay to 528138.
`default_nettype none
`include "ds_twr_range_calculator_top_assert.svh"
module ds_twr_range_calculator_top import dtr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [DLY_W-1:0] cfg_wdata,
  dtr_req_if.sink               req,
  dtr_rsp_if.source             rsp
);

  logic [DLY_W-1:0] ant_dly;

  always_ff @(posedge clk) begin
    if (rst) begin
      ant_dly <= DLY_RESET;
    end else if (cfg_we) begin
      ant_dly <= cfg_wdata;
    end
  end

  // stage 1: round trips
  logic               v1, r1;
  logic [TS_BITS-1:0] rtt1, rtt2, rep1, rep2;
  // stage 2: denominator and partial products
  logic               v2, r2;
  logic [DEN_W-1:0]   den2;
  logic [PP_W-1:0]    p_hh, p_hl, p_lh, p_ll, q_hh, q_hl, q_lh, q_ll;
  // stage 3: full products
  logic               v3, r3;
  logic [DEN_W-1:0]   den3;
  logic [PROD_W-1:0]  prod_p, prod_q;
  // stage 4: divider input
  logic               v4, r4;
  div_in_t            dv4;
  // divider output
  logic               dvo_valid, r5_in;
  div_out_t           dvo;
  // stage 5: delay removed
  logic               v5, r5;
  logic [QUO_W-1:0]   tof5;
  status_t            st5;
  // stage 6: scale products
  logic               v6, r6;
  logic [MP_W-1:0]    m_lo, m_hi;
  status_t            st6;
  // stage 7: output register
  logic               v7, r7;
  rsp_t               out7;

  logic [PROD_W:0]  pq_diff;
  logic [QUO_W:0]   tof_diff;
  logic [MSUM_W-1:0] m_sum;

  assign r7 = !v7 || rsp.ready;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r5_in = r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign req.ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r1) v1 <= req.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= dvo_valid;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && req.valid) begin
      rtt1 <= req.data.resp_recv_time - req.data.poll_send_time;
      rtt2 <= req.data.resp2_recv_time - req.data.poll2_send_time;
      rep1 <= req.data.reply_delay_one;
      rep2 <= req.data.reply_delay_two;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      den2 <= DEN_W'(rtt1) + DEN_W'(rtt2) + DEN_W'(rep1) + DEN_W'(rep2);
      p_hh <= rtt1[TS_BITS-1:HALF_W] * rtt2[TS_BITS-1:HALF_W];
      p_hl <= rtt1[TS_BITS-1:HALF_W] * rtt2[HALF_W-1:0];
      p_lh <= rtt1[HALF_W-1:0] * rtt2[TS_BITS-1:HALF_W];
      p_ll <= rtt1[HALF_W-1:0] * rtt2[HALF_W-1:0];
      q_hh <= rep1[TS_BITS-1:HALF_W] * rep2[TS_BITS-1:HALF_W];
      q_hl <= rep1[TS_BITS-1:HALF_W] * rep2[HALF_W-1:0];
      q_lh <= rep1[HALF_W-1:0] * rep2[TS_BITS-1:HALF_W];
      q_ll <= rep1[HALF_W-1:0] * rep2[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      den3   <= den2;
      prod_p <= (PROD_W'(p_hh) << (2 * HALF_W)) + (PROD_W'(p_hl) << HALF_W)
              + (PROD_W'(p_lh) << HALF_W) + PROD_W'(p_ll);
      prod_q <= (PROD_W'(q_hh) << (2 * HALF_W)) + (PROD_W'(q_hl) << HALF_W)
              + (PROD_W'(q_lh) << HALF_W) + PROD_W'(q_ll);
    end
  end

  assign pq_diff = {1'b0, prod_p} - {1'b0, prod_q};

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      dv4.dvd <= {pq_diff[PROD_W-1:0], TOF_FRAC_BITS'(0)};
      dv4.den <= den3;
      priority if (den3 == '0) begin
        dv4.st <= ST_ZDEN;
      end else if (pq_diff[PROD_W]) begin
        dv4.st <= ST_NEG;
      end else begin
        dv4.st <= ST_OK;
      end
    end
  end

  dtr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (r4),
    .in_data   (dv4),
    .out_valid (dvo_valid),
    .out_ready (r5_in),
    .out_data  (dvo)
  );

  assign tof_diff = {1'b0, dvo.quo} - (QUO_W + 1)'(ant_dly);

  always_ff @(posedge clk) begin
    if (r5 && dvo_valid) begin
      tof5 <= tof_diff[QUO_W-1:0];
      st5  <= (dvo.st == ST_OK && tof_diff[QUO_W]) ? ST_NEG : dvo.st;
    end
  end

  always_ff @(posedge clk) begin
    if (r6 && v5) begin
      m_lo <= tof5[MLO_W-1:0] * RANGE_SCALE;
      m_hi <= tof5[QUO_W-1:MLO_W] * RANGE_SCALE;
      st6  <= st5;
    end
  end

  assign m_sum = MSUM_W'(m_lo) + (MSUM_W'(m_hi) << MLO_W);

  always_ff @(posedge clk) begin
    if (r7 && v6) begin
      out7.status      <= st6;
      out7.distance_cm <= (st6 == ST_OK) ? DIST_W'(m_sum >> RANGE_SHIFT) : '0;
    end
  end

  assign rsp.valid = v7;
  assign rsp.data  = out7;

  `DTR_ASSERT(a_err_zero_dist,
    (rsp.valid && rsp.data.status != ST_OK) |-> (rsp.data.distance_cm == '0),
    "error result carries a nonzero distance")
  `DTR_ASSERT(a_zden_flag, (v4 && dv4.den == '0) |-> (dv4.st == ST_ZDEN),
    "zero denominator not flagged")
  `DTR_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp.valid, "result valid right after reset")

endmodule
`default_nettype wire

>>> rtl/dtr_div.sv
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module dtr_div import dtr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire div_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output div_out_t      out_data
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] rq;   // dividend bits shift out on top, quotient in at bottom
    logic [DEN_W-1:0] den;
    status_t          st;
  } stage_t;

  function automatic stage_t div_step(stage_t s);
    logic [REM_W:0]   t;
    logic [REM_W+1:0] d;
    logic             ge;
    stage_t           r;
    t  = {s.rem, s.rq[QUO_W-1]};
    d  = {1'b0, t} - {2'b00, s.den};
    ge = !d[REM_W+1];
    r  = s;
    r.rem = ge ? d[REM_W-1:0] : t[REM_W-1:0];
    r.rq  = {s.rq[QUO_W-2:0], ge};
    return r;
  endfunction

  stage_t           stg [QUO_W];
  logic [QUO_W-1:0] vld;
  logic [QUO_W:0]   rdy;
  stage_t           init;

  // quotient fits QUO_W bits, so the top dividend bits are already below den
  always_comb begin
    init.rem = REM_W'(in_data.dvd[DVD_W-1:QUO_W]);
    init.rq  = in_data.dvd[QUO_W-1:0];
    init.den = in_data.den;
    init.st  = in_data.st;
  end

  assign rdy[QUO_W] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    assign rdy[k] = !vld[k] || rdy[k+1];
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= in_valid;
        end
        if (rdy[k] && in_valid) begin
          stg[k] <= div_step(init);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
        if (rdy[k] && vld[k-1]) begin
          stg[k] <= div_step(stg[k-1]);
        end
      end
    end
  end

  assign out_valid    = vld[QUO_W-1];
  assign out_data.quo = stg[QUO_W-1].rq;
  assign out_data.st  = stg[QUO_W-1].st;

endmodule
`default_nettype wire
